// ----- sv/assert_macros.svh -----
// Assertion helpers, all sampled on clk and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lsws_pkg.sv -----
package lsws_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned DATA_W      = 32;

  localparam logic [DATA_W-1:0] EMPTY_TOP = '1;
  localparam logic [CNT_W-1:0]  FULL_LVL  = CNT_W'(STACK_DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  typedef struct packed {
    logic exec;      // apply the accepted request
    logic scan_rd;   // read port addresses the scan pointer
    logic scan_cmp;  // compare read word against the key, advance pointer
    logic load_out;  // load the result register
  } lsws_cmd_t;

  typedef struct packed {
    logic search_go; // incoming request is a search over a non-empty stack
    logic hit;
    logic scan_last;
  } lsws_stat_t;

endpackage

// ----- sv/lsws_dp.sv -----
`include "assert_macros.svh"

module lsws_dp
  import lsws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  lsws_cmd_t                cmd,
  output lsws_stat_t               stat,
  input  op_t                      in_op,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic [CNT_W-1:0]         in_pop_count,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic                     out_is_empty,
  output logic [CNT_W-1:0]         out_fill_level,
  output logic [CNT_W-1:0]         out_popped,
  output logic                     out_found,
  output logic [1:0]               out_status
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [CNT_W-1:0]  level_r, level_nxt;
  logic [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]  popped_r, popped_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              found_r;
  logic [ADDR_W-1:0] scan_idx_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  logic signed [DATA_W-1:0] out_top_r;
  logic                     out_empty_r;
  logic [CNT_W-1:0]         out_fill_r;
  logic [CNT_W-1:0]         out_popped_r;
  logic                     out_found_r;
  logic [1:0]               out_status_r;

  always_comb begin
    level_nxt  = level_r;
    popped_nxt = '0;
    status_nxt = STAT_OK;
    wr_en      = 1'b0;
    unique case (in_op)
      OP_PUSH: begin
        if (level_r == FULL_LVL) begin
          status_nxt = STAT_OVER;
        end else begin
          wr_en     = cmd.exec;
          level_nxt = level_r + 1'b1;
        end
      end
      OP_POP: begin
        if (in_pop_count > level_r) begin
          popped_nxt = level_r;
          status_nxt = STAT_UNDER;
        end else begin
          popped_nxt = in_pop_count;
        end
        level_nxt = level_r - popped_nxt;
      end
      OP_SEARCH, OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // top of stack unless the scan owns the port
  assign rd_addr = cmd.scan_rd ? scan_idx_r : ADDR_W'(level_r - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(level_r)] <= in_data_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cmd.exec) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      key_r      <= in_data_value;
      popped_r   <= popped_nxt;
      status_r   <= status_nxt;
      found_r    <= 1'b0;
      scan_idx_r <= '0;
    end else if (cmd.scan_cmp) begin
      if (stat.hit) begin
        found_r <= 1'b1;
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_top_r    <= (level_r == '0) ? EMPTY_TOP : rd_data_r;
      out_empty_r  <= (level_r == '0);
      out_fill_r   <= level_r;
      out_popped_r <= popped_r;
      out_found_r  <= found_r;
      out_status_r <= status_r;
    end
  end

  assign stat.search_go = (in_op == OP_SEARCH) && (level_r != '0);
  assign stat.hit       = (rd_data_r == key_r);
  assign stat.scan_last = ((CNT_W'(scan_idx_r) + 1'b1) == level_r);

  assign out_top_value  = out_top_r;
  assign out_is_empty   = out_empty_r;
  assign out_fill_level = out_fill_r;
  assign out_popped     = out_popped_r;
  assign out_found      = out_found_r;
  assign out_status     = out_status_r;

  `ASSERT_SAME(a_level_bound, 1'b1, level_r <= FULL_LVL, "stack level beyond depth")
  `ASSERT_NEXT(a_push_grows, cmd.exec && in_op == OP_PUSH && level_r != FULL_LVL,
               level_r == $past(level_r) + 1'b1, "push did not grow the stack")

endmodule

// ----- sv/lsws_ctrl.sv -----
`include "assert_macros.svh"

module lsws_ctrl
  import lsws_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  lsws_stat_t stat,
  output lsws_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN_RD  = 5'b00010,
    S_SCAN_CMP = 5'b00100,
    S_TOP_RD   = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.search_go ? S_SCAN_RD : S_TOP_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_nxt    = (stat.hit || stat.scan_last) ? S_TOP_RD : S_SCAN_RD;
      end
      S_TOP_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;

  `ASSERT_NEXT(a_one_request_at_a_time, in_tvalid && in_tready, !in_tready,
               "request taken while the previous one is still in work")
  `ASSERT_SAME(a_load_needs_room, cmd.load_out, !out_valid_r || out_tready,
               "result register overwritten before it was taken")
  `ASSERT_SAME(a_cmp_after_read, state_r == S_SCAN_CMP, $past(state_r) == S_SCAN_RD,
               "scan compare without a preceding read")

endmodule

// ----- sv/lifo_stack_with_search.sv -----
// Channel  | Ports                         | Contents
// ---------+-------------------------------+-----------------------------------------
// input    | in_tvalid/in_tready/in_tdata  | one request: push, pop or search
// result   | out_tvalid/out_tready/out_tdata | one result per request
//
// Push, pop and no-op go from request to result by apply, read top and load, in that order.
// A search adds a read and a compare per entry checked (single memory read port), over
// at most fill level entries, stopping at the first hit.
// One request is in work at a time; a new one is taken while the result waits.
// rst_n is synchronous, active low, and empties the stack; no memory clearing.
// A stalled result holds the next request in the output state until out_tready.
module lifo_stack_with_search
  import lsws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[1:0], data_value[33:2], pop_count[40:34], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // top_value[31:0], is_empty[32], fill_level[39:33],
                                  // popped[46:40], found[47], status[49:48], zero pad
);

  lsws_cmd_t  cmd;
  lsws_stat_t stat;

  logic signed [DATA_W-1:0] top_value;
  logic                     is_empty;
  logic [CNT_W-1:0]         fill_level;
  logic [CNT_W-1:0]         popped;
  logic                     found;
  logic [1:0]               status;

  lsws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lsws_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_op          (op_t'(in_tdata[1:0])),
    .in_data_value  (in_tdata[33:2]),
    .in_pop_count   (in_tdata[40:34]),
    .out_top_value  (top_value),
    .out_is_empty   (is_empty),
    .out_fill_level (fill_level),
    .out_popped     (popped),
    .out_found      (found),
    .out_status     (status)
  );

  assign out_tdata = {6'b0, status, found, popped, fill_level, is_empty, top_value};

endmodule
